// File: hw/rtl/rlct_pkg.sv
// rlct_pkg: types, codes and helpers shared by the led chain transmitter
// depends on nothing
`default_nettype none

package rlct_pkg;

  // item kinds
  localparam logic [2:0] KindSetPixel = 3'd0;
  localparam logic [2:0] KindSetAll   = 3'd1;
  localparam logic [2:0] KindClear    = 3'd2;
  localparam logic [2:0] KindShow     = 3'd3;
  localparam logic [2:0] KindTick     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] RegBrightness = 3'd0;
  localparam logic [2:0] RegPixelCount = 3'd1;
  localparam logic [2:0] RegZeroHigh   = 3'd2;
  localparam logic [2:0] RegZeroLow    = 3'd3;
  localparam logic [2:0] RegOneHigh    = 3'd4;
  localparam logic [2:0] RegOneLow     = 3'd5;
  localparam logic [2:0] RegLatch      = 3'd6;

  localparam int unsigned CfgDataW = 12;

  // byte lane within a pixel row: green, red, blue
  localparam logic [1:0] LaneLast = 2'd2;
  localparam logic [2:0] BitFirst = 3'd7;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [8:0]  pixel_count;
    logic [5:0]  zero_high;
    logic [5:0]  zero_low;
    logic [5:0]  one_high;
    logic [5:0]  one_low;
    logic [11:0] latch;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    brightness:  8'd255,
    pixel_count: 9'd256,
    zero_high:   6'd3,
    zero_low:    6'd9,
    one_high:    6'd9,
    one_low:     6'd3,
    latch:       12'd600
  };

  typedef struct packed {
    logic capture;      // take colour products and index of the item
    logic wr_one;       // write the scaled pixel at the taken index
    logic sweep_start;  // restart the row counter for a sweep
    logic fill_step;    // write the scaled pixel at the row counter
    logic clr_step;     // write zero at the row counter
    logic frame_start;  // show: reset pointers and fetch row zero
    logic frame_load;   // first row into the shift side, prefetch the next
    logic tick_high;
    logic tick_low;
    logic tick_latch;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic fill_last;
    logic clr_last;
    logic hit_high;
    logic hit_low;
    logic hit_latch;
    logic bit_last;
    logic byte_last;
  } dp_sts_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
    logic frame_done;
  } res_t;

  // x / 255 rounded down, exact for any product of two 8 bit values
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rlct_ctrl.sv
// rlct_ctrl: sequencer for store sweeps, frame fetch and the bit waveform
// depends on rlct_pkg
`default_nettype none

module rlct_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [2:0]       kind_i,
  input  rlct_pkg::dp_sts_t     sts_i,
  output rlct_pkg::dp_cmd_t     cmd_o,
  output rlct_pkg::res_t        res_o,
  output logic                  ready_o
);
  import rlct_pkg::*;

  typedef enum logic [7:0] {
    ST_CLR   = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_SET   = 8'b0000_0100,
    ST_FILL  = 8'b0000_1000,
    ST_LOAD  = 8'b0001_0000,
    ST_HIGH  = 8'b0010_0000,
    ST_LOW   = 8'b0100_0000,
    ST_LATCH = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   is_cmd, is_tick, tx_now;

  always_comb begin
    is_cmd  = (kind_i == KindSetPixel) || (kind_i == KindSetAll) ||
              (kind_i == KindClear) || (kind_i == KindShow);
    is_tick = (kind_i == KindTick);
    tx_now  = (state_q == ST_HIGH) || (state_q == ST_LOW) || (state_q == ST_LATCH);
    ready_o = (state_q == ST_IDLE) || tx_now;
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    res_o.line_level = 1'b0;
    res_o.rejected   = fire_i && tx_now && is_cmd;
    res_o.frame_done = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (fire_i) begin
          unique case (kind_i)
            KindSetPixel: begin
              cmd_o.capture = 1'b1;
              if (sts_i.idx_ok) state_d = ST_SET;
            end
            KindSetAll: begin
              cmd_o.capture     = 1'b1;
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_FILL;
            end
            KindClear: begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_CLR;
            end
            KindShow: begin
              cmd_o.frame_start = 1'b1;
              state_d           = ST_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_SET: begin
        cmd_o.wr_one = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) state_d = ST_IDLE;
      end
      ST_LOAD: begin
        cmd_o.frame_load = 1'b1;
        state_d          = ST_HIGH;
      end
      ST_HIGH: begin
        if (fire_i && is_tick) begin
          cmd_o.tick_high  = 1'b1;
          res_o.line_level = 1'b1;
          if (sts_i.hit_high) state_d = ST_LOW;
        end
      end
      ST_LOW: begin
        if (fire_i && is_tick) begin
          cmd_o.tick_low = 1'b1;
          if (sts_i.hit_low) begin
            if (sts_i.bit_last && sts_i.byte_last) state_d = ST_LATCH;
            else state_d = ST_HIGH;
          end
        end
      end
      ST_LATCH: begin
        if (fire_i && is_tick) begin
          cmd_o.tick_latch = 1'b1;
          if (sts_i.hit_latch) begin
            res_o.frame_done = 1'b1;
            state_d          = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    res_o.busy_res = (state_d == ST_LOAD) || (state_d == ST_HIGH) ||
                     (state_d == ST_LOW) || (state_d == ST_LATCH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rlct_dpath.sv
// rlct_dpath: pixel memory, colour scaling, bit and byte pointers, tick counter
// depends on rlct_pkg
`default_nettype none

module rlct_dpath #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  rlct_pkg::cfg_t       cfg_i,
  input  rlct_pkg::dp_cmd_t    cmd_i,
  input  wire logic [7:0]      pixel_index_i,
  input  wire logic [7:0]      red_i,
  input  wire logic [7:0]      green_i,
  input  wire logic [7:0]      blue_i,
  output rlct_pkg::dp_sts_t    sts_o
);
  import rlct_pkg::*;

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned XW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam logic [AW-1:0] RowMax = AW'(MAX_PIXELS - 1);
  localparam logic [XW-1:0] MaxX   = XW'(MAX_PIXELS);

  logic [23:0]   pix_mem [MAX_PIXELS];
  logic [23:0]   rd_q;
  logic [23:0]   cur_row_q, cur_row_d;
  logic [15:0]   prod_g_q, prod_r_q, prod_b_q;
  logic [AW-1:0] idx_q;
  logic [AW-1:0] row_q, row_d;
  logic [1:0]    lane_q, lane_d;
  logic [2:0]    bit_q, bit_d;
  logic [11:0]   cnt_q, cnt_d;

  logic [XW-1:0] pc_x, act_m1_x, idx_x;
  logic [AW-1:0] act_m1;
  logic [AW:0]   row_p1, row_p2;
  logic [7:0]    cur_byte;
  logic          cur_bit;
  logic [5:0]    lim_high, lim_low;
  logic [11:0]   lim_latch;
  logic [12:0]   cnt_inc;
  logic          byte_adv, row_adv;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [23:0]   wd;

  // active pixel count minus one, saturated into range
  always_comb begin
    pc_x  = XW'(cfg_i.pixel_count);
    idx_x = XW'(pixel_index_i);
    if (pc_x == '0) act_m1_x = '0;
    else if (pc_x > MaxX) act_m1_x = MaxX - XW'(1);
    else act_m1_x = pc_x - XW'(1);
    act_m1 = act_m1_x[AW-1:0];
  end

  always_comb begin
    row_p1 = {1'b0, row_q} + (AW+1)'(1);
    row_p2 = {1'b0, row_q} + (AW+1)'(2);
    unique case (lane_q)
      2'd0:    cur_byte = cur_row_q[23:16];
      2'd1:    cur_byte = cur_row_q[15:8];
      default: cur_byte = cur_row_q[7:0];
    endcase
    cur_bit   = cur_byte[bit_q];
    lim_high  = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
    lim_low   = cur_bit ? cfg_i.one_low : cfg_i.zero_low;
    if (lim_high == '0) lim_high = 6'd1;
    if (lim_low == '0) lim_low = 6'd1;
    lim_latch = (cfg_i.latch == '0) ? 12'd1 : cfg_i.latch;
    cnt_inc   = {1'b0, cnt_q} + 13'd1;
  end

  always_comb begin
    sts_o.idx_ok    = idx_x <= act_m1_x;
    sts_o.fill_last = row_q == act_m1;
    sts_o.clr_last  = row_q == RowMax;
    sts_o.hit_high  = cnt_inc >= 13'(lim_high);
    sts_o.hit_low   = cnt_inc >= 13'(lim_low);
    sts_o.hit_latch = cnt_inc >= 13'(lim_latch);
    sts_o.bit_last  = bit_q == '0;
    // reached or passed the last byte of the active chain
    sts_o.byte_last = (row_q > act_m1) || ((row_q == act_m1) && (lane_q == LaneLast));
  end

  always_comb begin
    byte_adv = cmd_i.tick_low && sts_o.hit_low && sts_o.bit_last && !sts_o.byte_last;
    row_adv  = byte_adv && (lane_q == LaneLast);

    row_d     = row_q;
    lane_d    = lane_q;
    bit_d     = bit_q;
    cnt_d     = cnt_q;
    cur_row_d = cur_row_q;

    if (cmd_i.sweep_start || cmd_i.frame_start) row_d = '0;
    else if (cmd_i.fill_step || cmd_i.clr_step || row_adv) row_d = row_p1[AW-1:0];

    if (cmd_i.frame_start) lane_d = '0;
    else if (byte_adv) lane_d = (lane_q == LaneLast) ? 2'd0 : lane_q + 2'd1;

    if (cmd_i.frame_start) begin
      bit_d = BitFirst;
      cnt_d = '0;
    end else if (cmd_i.tick_high) begin
      cnt_d = sts_o.hit_high ? 12'd0 : cnt_inc[11:0];
    end else if (cmd_i.tick_low) begin
      cnt_d = sts_o.hit_low ? 12'd0 : cnt_inc[11:0];
      if (sts_o.hit_low) begin
        if (!sts_o.bit_last) bit_d = bit_q - 3'd1;
        else if (!sts_o.byte_last) bit_d = BitFirst;
      end
    end else if (cmd_i.tick_latch) begin
      cnt_d = sts_o.hit_latch ? 12'd0 : cnt_inc[11:0];
      if (sts_o.hit_latch) bit_d = BitFirst;
    end

    // next row was prefetched into the read register
    if (cmd_i.frame_load || row_adv) cur_row_d = rd_q;
  end

  // memory port control
  always_comb begin
    we = cmd_i.wr_one || cmd_i.fill_step || cmd_i.clr_step;
    wa = cmd_i.wr_one ? idx_q : row_q;
    wd = cmd_i.clr_step ? 24'd0
                        : {div255(prod_g_q), div255(prod_r_q), div255(prod_b_q)};
    re = cmd_i.frame_start || cmd_i.frame_load || row_adv;
    priority if (cmd_i.frame_start) ra = '0;
    else if (cmd_i.frame_load) ra = row_p1[AW-1:0];
    else ra = row_p2[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (we) pix_mem[wa] <= wd;
    if (re) rd_q <= pix_mem[ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      prod_g_q <= 16'(green_i) * 16'(cfg_i.brightness);
      prod_r_q <= 16'(red_i) * 16'(cfg_i.brightness);
      prod_b_q <= 16'(blue_i) * 16'(cfg_i.brightness);
      idx_q    <= idx_x[AW-1:0];
    end
    cur_row_q <= cur_row_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      lane_q <= '0;
      bit_q  <= BitFirst;
      cnt_q  <= '0;
    end else begin
      row_q  <= row_d;
      lane_q <= lane_d;
      bit_q  <= bit_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rgb_led_chain_transmitter_core.sv
// rgb_led_chain_transmitter_core: top level with config registers and result register
// depends on rlct_pkg, rlct_ctrl, rlct_dpath
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | in        | in_valid_i/in_stall_o | kind, pixel_index, red, green, blue
//   out     | out       | out_valid_o/out_stall_i | line_level, busy_res, rejected, frame_done
//   cfg     | in        | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
// tick items: one per cycle unless a stalled result holds the input off; the waveform counter is the only loop per item
// set_pixel multiplies first, then scales and writes; set_all captures, then writes every active pixel
// clear writes all MAX_PIXELS rows, one memory row per cycle; show fetches row zero, then loads it
// after reset a clearing pass over all MAX_PIXELS rows runs and no item is taken
// a stalled result in the result register holds the input off until it is taken
`default_nettype none

module rgb_led_chain_transmitter_core #(
  parameter int unsigned MAX_PIXELS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [7:0]  pixel_index_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             line_level_o,
  output logic             busy_res_o,
  output logic             rejected_o,
  output logic             frame_done_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [rlct_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rlct_pkg::*;

  cfg_t    cfg_q, cfg_d;
  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res, res_q;
  logic    out_valid_q, out_valid_d;
  logic    ctrl_ready, out_free, fire;

  always_comb begin
    out_free   = !out_valid_q || !out_stall_i;
    in_stall_o = !(out_free && ctrl_ready);
    fire       = in_valid_i && !in_stall_o;
  end

  rlct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .res_o   (res),
    .ready_o (ctrl_ready)
  );

  rlct_dpath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .pixel_index_i (pixel_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .sts_o         (sts)
  );

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegBrightness: cfg_d.brightness  = cfg_wdata_i[7:0];
        RegPixelCount: cfg_d.pixel_count = cfg_wdata_i[8:0];
        RegZeroHigh:   cfg_d.zero_high   = cfg_wdata_i[5:0];
        RegZeroLow:    cfg_d.zero_low    = cfg_wdata_i[5:0];
        RegOneHigh:    cfg_d.one_high    = cfg_wdata_i[5:0];
        RegOneLow:     cfg_d.one_low     = cfg_wdata_i[5:0];
        RegLatch:      cfg_d.latch       = cfg_wdata_i[11:0];
        default: ;
      endcase
    end
    out_valid_d = fire || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res;
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = res_q.line_level;
  assign busy_res_o   = res_q.busy_res;
  assign rejected_o   = res_q.rejected;
  assign frame_done_o = res_q.frame_done;

endmodule

`default_nettype wire

// File: hw/rtl/rlct_checker.sv
// rlct_checker: port level properties of the led chain transmitter, bound to the top
// depends on rgb_led_chain_transmitter_core
`default_nettype none

module rlct_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic line_level_o,
  input wire logic busy_res_o,
  input wire logic rejected_o,
  input wire logic frame_done_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_level_o) &&
    $stable(busy_res_o) && $stable(rejected_o) && $stable(frame_done_o))
    else $error("stalled result changed");

  // a refused command leaves the transmission running
  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> busy_res_o)
    else $error("rejected item without busy");

  // end of latch returns to idle with the line low
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !busy_res_o && !line_level_o && !rejected_o)
    else $error("frame_done with busy or line high");

  // the line is only driven high inside a frame
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_level_o |-> busy_res_o)
    else $error("line high while idle");

endmodule

bind rgb_led_chain_transmitter_core rlct_checker u_rlct_checker (.*);

`default_nettype wire
